// ===== hw/rtl/alert_tone_pattern_sequencer_assert.svh =====
// Assertion macros for the checker file of the alert tone sequencer.
`ifndef ALERT_TONE_PATTERN_SEQUENCER_ASSERT_SVH
`define ALERT_TONE_PATTERN_SEQUENCER_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define ATPS_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Condition implies consequence in the next cycle.
`define ATPS_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== hw/rtl/atps_pkg.sv =====
// Package with types, codes, the pattern lookup and the jingle note table.
package atps_pkg;

    localparam int JINGLE_NOTES_DEF = 8;
    localparam int CFG_IDX_W        = 8;
    localparam int CFG_DATA_W       = 32;

    localparam logic [1:0] VOICE_NONE    = 2'd0;
    localparam logic [1:0] VOICE_TRAFFIC = 2'd1;
    localparam logic [1:0] VOICE_JINGLE  = 2'd2;

    localparam logic [1:0] LVL_NONE      = 2'd0;
    localparam logic [1:0] LVL_INFO      = 2'd1;
    localparam logic [1:0] LVL_IMPORTANT = 2'd2;
    localparam logic [1:0] LVL_URGENT    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_INFO_TONE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INFO_COUNT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_TONE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_COUNT = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIN_TONE = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIN_CNT  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REANNOUNCE = 8'd6;

    typedef struct packed {
        logic [15:0] info_tone_ms;
        logic [7:0]  info_count;
        logic [15:0] pair_tone_ms;
        logic [7:0]  pair_count;
        logic [15:0] train_tone_ms;
        logic [7:0]  train_count;
        logic [31:0] repeat_ms;
    } cfg_t;

    typedef struct packed {
        logic [15:0] tone;
        logic [15:0] gap;
        logic [7:0]  count;
        logic [31:0] reannounce;
    } pat_t;

    typedef struct packed {
        logic [15:0] hz;
        logic [15:0] tone_ms;
        logic [15:0] gap_ms;
    } note_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic front;
        logic step;
        logic result;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run_en;
        logic step_done;
        logic res_free;
    } sts_t;

    // Tone pattern for a traffic level, taken from the registers.
    function automatic pat_t traffic_pattern(logic [1:0] level, cfg_t cfg);
        pat_t p;
        p = '0;
        unique case (level)
            LVL_INFO:
            begin
                p.tone  = cfg.info_tone_ms;
                p.count = cfg.info_count;
            end
            LVL_IMPORTANT:
            begin
                p.tone  = cfg.pair_tone_ms;
                p.gap   = cfg.pair_tone_ms;
                p.count = cfg.pair_count;
            end
            LVL_URGENT:
            begin
                p.tone       = cfg.train_tone_ms;
                p.gap        = cfg.train_tone_ms;
                p.count      = cfg.train_count;
                p.reannounce = cfg.repeat_ms;
            end
            default: p = '0;
        endcase
        return p;
    endfunction

    // First-fix jingle notes; a zero gap ends the jingle.
    function automatic note_t jingle_note(logic [5:0] idx);
        note_t n;
        unique case (idx)
            6'd0:    n = '{16'd523,  16'd80,  16'd20};
            6'd1:    n = '{16'd659,  16'd80,  16'd20};
            6'd2:    n = '{16'd784,  16'd80,  16'd20};
            6'd3:    n = '{16'd1047, 16'd120, 16'd40};
            6'd4:    n = '{16'd784,  16'd80,  16'd20};
            6'd5:    n = '{16'd1047, 16'd80,  16'd20};
            6'd6:    n = '{16'd1319, 16'd80,  16'd20};
            6'd7:    n = '{16'd1568, 16'd240, 16'd0};
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

// ===== hw/rtl/atps_upd_if.sv =====
// Update channel interface carrying one input item.
interface atps_upd_if;
    logic        valid;
    logic        ready;
    logic        running;
    logic        enabled;
    logic [1:0]  alert_level;
    logic        escalated;
    logic        fix_req;
    logic [31:0] now_ms;

    modport source (output valid, running, enabled, alert_level, escalated, fix_req,
                    now_ms, input ready);
    modport sink (input valid, running, enabled, alert_level, escalated, fix_req,
                  now_ms, output ready);
endinterface

// ===== hw/rtl/atps_res_if.sv =====
// Result channel interface carrying one tone item.
interface atps_res_if;
    logic        valid;
    logic        ready;
    logic        tone_on;
    logic [1:0]  tone_lvl;
    logic [15:0] tone_freq_hz;
    logic        changed;

    modport source (output valid, tone_on, tone_lvl, tone_freq_hz, changed, input ready);
    modport sink (input valid, tone_on, tone_lvl, tone_freq_hz, changed, output ready);
endinterface

// ===== hw/rtl/atps_cfg_if.sv =====
// Configuration write channel interface.
interface atps_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/alert_tone_pattern_sequencer.sv =====
// Top level of the alert tone pattern sequencer.
// Usage:
// The upd channel takes one update item: system flags, alert level, escalation,
// first-fix request and the time in milliseconds. The res channel returns one
// item per update: tone on, tone level, jingle frequency and a changed flag.
// The cfg channel writes the pattern registers; it is always ready and should
// be used only while the block is idle.
// A running and enabled update steps through the tone and gap phases that have
// elapsed, one per cycle through a single subtract-and-compare unit, before its
// result is loaded; the phases caught up reach about twice the beep count of the
// pattern, or 15 for the jingle. A silenced update skips the steps.
// The next update is accepted in the cycle after the result is loaded.
// A stalled receiver holds the result in the output register; the next update
// is still accepted and worked, then waits for the output register, which
// holds off further updates.
// Reset silences the voice, clears the history used for the changed flag and
// loads the register defaults.
module alert_tone_pattern_sequencer #(
    parameter int JINGLE_NOTES = atps_pkg::JINGLE_NOTES_DEF
) (
    input logic   clk,
    input logic   rst_n,
    atps_upd_if.sink   upd,
    atps_res_if.source res,
    atps_cfg_if.sink   cfg
);
    import atps_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg.ready = 1'b1;

    atps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (upd.valid),
        .in_ready (upd.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    atps_datapath #(
        .JINGLE_NOTES (JINGLE_NOTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .running      (upd.running),
        .enabled      (upd.enabled),
        .alert_level  (upd.alert_level),
        .escalated    (upd.escalated),
        .fix_req      (upd.fix_req),
        .now_ms       (upd.now_ms),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .res_ready    (res.ready),
        .res_valid    (res.valid),
        .tone_on      (res.tone_on),
        .tone_lvl     (res.tone_lvl),
        .tone_freq_hz (res.tone_freq_hz),
        .changed      (res.changed),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

// ===== hw/rtl/atps_ctrl.sv =====
// Controller state machine sequencing update, catch-up steps and result.
module atps_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  atps_pkg::sts_t sts,
    output atps_pkg::cmd_t cmd
);
    import atps_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FRONT = 2'd1;
    localparam logic [1:0] S_ADV   = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_FRONT;
                end
            end
            S_FRONT:
            begin
                cmd.front  = 1'b1;
                state_next = sts.run_en ? S_ADV : S_OUT;
            end
            S_ADV:
            begin
                cmd.step = 1'b1;
                if (sts.step_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.res_free)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/atps_datapath.sv =====
// Datapath with registers, voice state, one catch-up phase per step and result register.
module atps_datapath #(
    parameter int JINGLE_NOTES = atps_pkg::JINGLE_NOTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             running,
    input  logic                             enabled,
    input  logic [1:0]                       alert_level,
    input  logic                             escalated,
    input  logic                             fix_req,
    input  logic [31:0]                      now_ms,
    input  logic                             cfg_valid,
    input  logic [atps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [atps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             res_ready,
    output logic                             res_valid,
    output logic                             tone_on,
    output logic [1:0]                       tone_lvl,
    output logic [15:0]                      tone_freq_hz,
    output logic                             changed,
    input  atps_pkg::cmd_t                   cmd,
    output atps_pkg::sts_t                   sts
);
    import atps_pkg::*;

    localparam int NIDX_W = (JINGLE_NOTES > 1) ? $clog2(JINGLE_NOTES) : 1;

    cfg_t cfg_reg, cfg_next;

    // Latched update fields.
    logic        run_reg, run_next, en_reg, en_next, esc_reg, esc_next, ff_reg, ff_next;
    logic [1:0]  lvl_in_reg, lvl_in_next;
    logic [31:0] now_reg, now_next;

    // Voice state.
    logic [1:0]        voice_reg, voice_next, level_reg, level_next;
    logic [31:0]       ann_reg, ann_next, ps_reg, ps_next;
    logic [NIDX_W-1:0] idx_reg, idx_next;
    logic [15:0]       freq_reg, freq_next;
    logic [7:0]        said_reg, said_next;
    logic              tone_reg, tone_next;
    pat_t              pat_reg, pat_next;

    // Previous result and the result register.
    logic        last_on_reg, last_on_next;
    logic [1:0]  last_lvl_reg, last_lvl_next;
    logic [15:0] last_hz_reg, last_hz_next;
    logic        ovalid_reg, ovalid_next;
    logic        oon_reg, oon_next, och_reg, och_next;
    logic [1:0]  olvl_reg, olvl_next;
    logic [15:0] ohz_reg, ohz_next;

    logic step_done;

    // Register writes; indexes beyond the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_INFO_TONE:  cfg_next.info_tone_ms  = cfg_data[15:0];
                REG_INFO_COUNT: cfg_next.info_count    = cfg_data[7:0];
                REG_PAIR_TONE:  cfg_next.pair_tone_ms  = cfg_data[15:0];
                REG_PAIR_COUNT: cfg_next.pair_count    = cfg_data[7:0];
                REG_TRAIN_TONE: cfg_next.train_tone_ms = cfg_data[15:0];
                REG_TRAIN_CNT:  cfg_next.train_count   = cfg_data[7:0];
                REG_REANNOUNCE: cfg_next.repeat_ms     = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // Voice update for the current command.
    always_comb
    begin
        pat_t        p;
        note_t       n;
        logic [31:0] d_phase;
        logic [31:0] d_ann;
        logic        on;
        logic [1:0]  lvl_o;
        logic [15:0] hz_o;

        run_next = run_reg; en_next = en_reg; esc_next = esc_reg; ff_next = ff_reg;
        lvl_in_next = lvl_in_reg; now_next = now_reg;
        voice_next = voice_reg; level_next = level_reg; ann_next = ann_reg;
        ps_next = ps_reg; idx_next = idx_reg; freq_next = freq_reg;
        said_next = said_reg; tone_next = tone_reg; pat_next = pat_reg;
        last_on_next = last_on_reg; last_lvl_next = last_lvl_reg;
        last_hz_next = last_hz_reg;
        oon_next = oon_reg; olvl_next = olvl_reg; ohz_next = ohz_reg; och_next = och_reg;
        ovalid_next = ovalid_reg && !res_ready;
        step_done = 1'b1;
        p = '0;
        n = '0;
        d_phase = now_reg - ps_reg;
        d_ann   = now_reg - ann_reg;
        on    = (voice_reg != VOICE_NONE) && tone_reg;
        lvl_o = on ? level_reg : LVL_NONE;
        hz_o  = on ? freq_reg : 16'd0;

        priority if (cmd.latch)
        begin
            run_next = running; en_next = enabled; esc_next = escalated;
            ff_next = fix_req; lvl_in_next = alert_level; now_next = now_ms;
        end
        else if (cmd.front)
        begin
            if (!(run_reg && en_reg))
            begin
                voice_next = VOICE_NONE; freq_next = '0; level_next = LVL_NONE;
                said_next = '0; tone_next = 1'b0;
            end
            else
            begin
                if (lvl_in_reg != LVL_NONE)
                begin
                    // Traffic start on a new level or escalation.
                    if (voice_reg != VOICE_TRAFFIC || level_reg != lvl_in_reg || esc_reg)
                    begin
                        p = traffic_pattern(lvl_in_reg, cfg_reg);
                        voice_next = VOICE_TRAFFIC; level_next = lvl_in_reg; pat_next = p;
                        ann_next = now_reg; ps_next = now_reg; idx_next = '0;
                        freq_next = '0;
                        said_next = (p.count != 8'd0) ? 8'd1 : 8'd0;
                        tone_next = (p.count != 8'd0) && (p.tone != 16'd0);
                        if (!tone_next)
                        begin
                            voice_next = VOICE_NONE; level_next = LVL_NONE;
                            said_next = '0;
                        end
                    end
                end
                else if (voice_reg == VOICE_TRAFFIC)
                begin
                    voice_next = VOICE_NONE; freq_next = '0; level_next = LVL_NONE;
                    said_next = '0; tone_next = 1'b0;
                end
                // Jingle start while no traffic voice is active.
                if (ff_reg && voice_next != VOICE_TRAFFIC)
                begin
                    voice_next = VOICE_JINGLE; level_next = LVL_NONE; pat_next = '0;
                    ann_next = now_reg; ps_next = now_reg; idx_next = '0;
                    freq_next = jingle_note(6'd0).hz; said_next = 8'd1; tone_next = 1'b1;
                end
            end
        end
        else if (cmd.step)
        begin
            unique case (voice_reg)
                VOICE_JINGLE:
                begin
                    n = jingle_note(6'(idx_reg));
                    if (tone_reg)
                    begin
                        if (d_phase >= {16'd0, n.tone_ms})
                        begin
                            ps_next = ps_reg + {16'd0, n.tone_ms};
                            tone_next = 1'b0;
                            step_done = 1'b0;
                        end
                    end
                    else if (n.gap_ms == 16'd0 ||
                             (7'(idx_reg) + 7'd1) >= 7'(JINGLE_NOTES))
                    begin
                        voice_next = VOICE_NONE; freq_next = '0; level_next = LVL_NONE;
                        said_next = '0; tone_next = 1'b0;
                    end
                    else if (d_phase >= {16'd0, n.gap_ms})
                    begin
                        ps_next = ps_reg + {16'd0, n.gap_ms};
                        idx_next = idx_reg + NIDX_W'(1);
                        said_next = said_reg + 8'd1;
                        freq_next = jingle_note(6'(idx_reg) + 6'd1).hz;
                        tone_next = 1'b1;
                        step_done = 1'b0;
                    end
                end
                VOICE_TRAFFIC:
                begin
                    if (tone_reg)
                    begin
                        if (d_phase >= {16'd0, pat_reg.tone})
                        begin
                            ps_next = ps_reg + {16'd0, pat_reg.tone};
                            tone_next = 1'b0;
                            step_done = 1'b0;
                        end
                    end
                    else if (said_reg >= pat_reg.count || pat_reg.gap == 16'd0)
                    begin
                        // Pattern over: restart once the re-announce interval is up.
                        if (pat_reg.reannounce != 32'd0 && d_ann >= pat_reg.reannounce)
                        begin
                            p = traffic_pattern(level_reg, cfg_reg);
                            pat_next = p;
                            ann_next = now_reg; ps_next = now_reg; idx_next = '0;
                            freq_next = '0;
                            said_next = (p.count != 8'd0) ? 8'd1 : 8'd0;
                            tone_next = (p.count != 8'd0) && (p.tone != 16'd0);
                            if (!tone_next)
                            begin
                                voice_next = VOICE_NONE; level_next = LVL_NONE;
                                said_next = '0;
                            end
                        end
                    end
                    else if (d_phase >= {16'd0, pat_reg.gap})
                    begin
                        ps_next = ps_reg + {16'd0, pat_reg.gap};
                        tone_next = 1'b1;
                        said_next = said_reg + 8'd1;
                        step_done = 1'b0;
                    end
                end
                default: step_done = 1'b1;
            endcase
        end
        else if (cmd.result)
        begin
            oon_next = on; olvl_next = lvl_o; ohz_next = hz_o;
            och_next = (on != last_on_reg) || (lvl_o != last_lvl_reg) ||
                       (hz_o != last_hz_reg);
            last_on_next = on; last_lvl_next = lvl_o; last_hz_next = hz_o;
            ovalid_next = 1'b1;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{16'd60, 8'd1, 16'd150, 8'd2, 16'd100, 8'd5, 32'd10000};
            voice_reg <= VOICE_NONE; level_reg <= LVL_NONE; ann_reg <= '0; ps_reg <= '0;
            idx_reg <= '0; freq_reg <= '0; said_reg <= '0; tone_reg <= 1'b0;
            pat_reg <= '0;
            last_on_reg <= 1'b0; last_lvl_reg <= '0; last_hz_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            voice_reg <= voice_next; level_reg <= level_next; ann_reg <= ann_next;
            ps_reg <= ps_next; idx_reg <= idx_next; freq_reg <= freq_next;
            said_reg <= said_next; tone_reg <= tone_next; pat_reg <= pat_next;
            last_on_reg <= last_on_next; last_lvl_reg <= last_lvl_next;
            last_hz_reg <= last_hz_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        run_reg <= run_next; en_reg <= en_next; esc_reg <= esc_next; ff_reg <= ff_next;
        lvl_in_reg <= lvl_in_next; now_reg <= now_next;
        oon_reg <= oon_next; olvl_reg <= olvl_next; ohz_reg <= ohz_next;
        och_reg <= och_next;
    end

    assign sts.run_en    = run_reg && en_reg;
    assign sts.step_done = step_done;
    assign sts.res_free  = !ovalid_reg || res_ready;

    assign res_valid    = ovalid_reg;
    assign tone_on      = oon_reg;
    assign tone_lvl     = olvl_reg;
    assign tone_freq_hz = ohz_reg;
    assign changed      = och_reg;

endmodule

// ===== hw/rtl/atps_checker.sv =====
// Port-level checker for the alert tone sequencer and its bind.
`include "alert_tone_pattern_sequencer_assert.svh"

module atps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic        tone_on,
    input logic [1:0]  tone_lvl,
    input logic [15:0] tone_freq_hz
);
    logic in_take;
    logic res_stall;
    logic res_silent;
    logic silent_zero;
    logic one_voice;

    // Handshake and payload terms used by the properties.
    assign in_take     = in_valid && in_ready;
    assign res_stall   = res_valid && !res_ready;
    assign res_silent  = res_valid && !tone_on;
    assign silent_zero = (tone_lvl == 2'd0) && (tone_freq_hz == 16'd0);
    assign one_voice   = (tone_lvl == 2'd0) || (tone_freq_hz == 16'd0);

    // A stalled result item stays offered.
    `ATPS_ASSERT_NEXT(a_res_hold, clk, rst_n, res_stall, res_valid, "result dropped")
    // One update is worked at a time: no acceptance right after one.
    `ATPS_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_take, !in_ready, "update overlap")
    // A silent result carries no level and no frequency.
    `ATPS_ASSERT_NOW(a_silent_zero, clk, rst_n, res_silent, silent_zero, "silent not zero")
    // Traffic tones and jingle notes never mix.
    `ATPS_ASSERT_NOW(a_voice_excl, clk, rst_n, res_valid, one_voice, "level and frequency set")
endmodule

bind alert_tone_pattern_sequencer atps_checker u_atps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (upd.valid),
    .in_ready     (upd.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .tone_on      (res.tone_on),
    .tone_lvl     (res.tone_lvl),
    .tone_freq_hz (res.tone_freq_hz)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the alert tone pattern sequencer.
`timescale 1ns / 100ps

module tb;
    import atps_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int          RAND_ITEMS  = 1500;
    localparam int          PHASES      = 6;
    localparam logic [7:0]  REG_SPARE_LO = 8'd7;
    localparam logic [7:0]  REG_SPARE_HI = 8'hFF;
    localparam logic        NO  = 1'b0;
    localparam logic        YES = 1'b1;

    // One update with an optional hand-written expectation.
    typedef struct {
        logic        running;
        logic        enabled;
        logic [1:0]  level;
        logic        escalated;
        logic        fix_req;
        logic [31:0] now_ms;
        bit          typed;
        logic        exp_on;
        logic [1:0]  exp_level;
        logic [15:0] exp_hz;
        logic        exp_changed;
    } upd_row_t;

    typedef struct packed {
        logic        tone_on;
        logic [1:0]  tone_lvl;
        logic [15:0] tone_freq_hz;
        logic        changed;
    } tone_t;

    logic clk;
    logic rst_n;

    atps_upd_if upd_ch ();
    atps_res_if res_ch ();
    atps_cfg_if cfg_ch ();

    alert_tone_pattern_sequencer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // Own copy of the jingle notes.
    logic [15:0] note_hz  [8] = '{523, 659, 784, 1047, 784, 1047, 1319, 1568};
    logic [15:0] note_len [8] = '{80, 80, 80, 120, 80, 80, 80, 240};
    logic [15:0] note_rest[8] = '{20, 20, 20, 40, 20, 20, 20, 0};

    // Predictor state.
    cfg_t        regs;
    logic [1:0]  voice;
    logic [1:0]  v_level;
    logic [31:0] announce_t;
    logic [31:0] phase_t;
    logic [2:0]  note_no;
    logic [15:0] freq;
    logic [7:0]  said;
    logic        in_tone;
    logic        prev_on;
    logic [1:0]  prev_level;
    logic [15:0] prev_hz;
    logic [15:0] pat_tone;
    logic [15:0] pat_gap;
    logic [7:0]  pat_count;
    logic [31:0] pat_again;

    tone_t tones_due[$];
    int    errors;
    int    sent;
    bit    no_idle;
    bit    hold_res;
    int unsigned cycles;

    // Register state after reset.
    function automatic void regs_reset();
        regs.info_tone_ms  = 16'd60;
        regs.info_count    = 8'd1;
        regs.pair_tone_ms  = 16'd150;
        regs.pair_count    = 8'd2;
        regs.train_tone_ms = 16'd100;
        regs.train_count   = 8'd5;
        regs.repeat_ms     = 32'd10000;
    endfunction

    function automatic void regs_write(logic [7:0] idx, logic [31:0] data);
        case (idx)
            REG_INFO_TONE:  regs.info_tone_ms  = data[15:0];
            REG_INFO_COUNT: regs.info_count    = data[7:0];
            REG_PAIR_TONE:  regs.pair_tone_ms  = data[15:0];
            REG_PAIR_COUNT: regs.pair_count    = data[7:0];
            REG_TRAIN_TONE: regs.train_tone_ms = data[15:0];
            REG_TRAIN_CNT:  regs.train_count   = data[7:0];
            REG_REANNOUNCE: regs.repeat_ms     = data;
            default: ;
        endcase
    endfunction

    function automatic void silence();
        voice   = VOICE_NONE;
        freq    = '0;
        v_level = LVL_NONE;
        said    = '0;
        in_tone = 1'b0;
    endfunction

    // Start a voice and latch its pattern from the registers.
    function automatic void begin_voice(logic [1:0] v, logic [1:0] lvl, logic [31:0] now);
        voice     = v;
        v_level   = lvl;
        pat_tone  = '0;
        pat_gap   = '0;
        pat_count = '0;
        pat_again = '0;
        if (v == VOICE_TRAFFIC)
        begin
            case (lvl)
                LVL_INFO:
                begin
                    pat_tone  = regs.info_tone_ms;
                    pat_count = regs.info_count;
                end
                LVL_IMPORTANT:
                begin
                    pat_tone  = regs.pair_tone_ms;
                    pat_gap   = regs.pair_tone_ms;
                    pat_count = regs.pair_count;
                end
                LVL_URGENT:
                begin
                    pat_tone  = regs.train_tone_ms;
                    pat_gap   = regs.train_tone_ms;
                    pat_count = regs.train_count;
                    pat_again = regs.repeat_ms;
                end
                default: ;
            endcase
        end
        announce_t = now;
        phase_t    = now;
        note_no    = '0;
        freq       = '0;
        if (v == VOICE_JINGLE)
        begin
            freq    = note_hz[0];
            said    = 8'd1;
            in_tone = 1'b1;
            return;
        end
        said    = (pat_count != 0) ? 8'd1 : 8'd0;
        in_tone = (pat_count != 0) && (pat_tone != 0);
        if (!in_tone)
            silence();
    endfunction

    // Walk the jingle through every note and rest that has elapsed.
    function automatic void jingle_catch_up(logic [31:0] now);
        forever
        begin
            if (in_tone)
            begin
                if ((now - phase_t) < note_len[note_no])
                    return;
                phase_t = phase_t + note_len[note_no];
                in_tone = 1'b0;
                continue;
            end
            if (note_rest[note_no] == 0 || note_no == 3'd7)
            begin
                silence();
                return;
            end
            if ((now - phase_t) < note_rest[note_no])
                return;
            phase_t = phase_t + note_rest[note_no];
            note_no = note_no + 3'd1;
            said    = said + 8'd1;
            freq    = note_hz[note_no];
            in_tone = 1'b1;
        end
    endfunction

    // Walk the traffic pattern through elapsed phases, then check re-announce.
    function automatic void voice_catch_up(logic [31:0] now);
        if (voice == VOICE_NONE)
            return;
        if (voice == VOICE_JINGLE)
        begin
            jingle_catch_up(now);
            return;
        end
        forever
        begin
            if (in_tone)
            begin
                if ((now - phase_t) < pat_tone)
                    return;
                phase_t = phase_t + pat_tone;
                in_tone = 1'b0;
                continue;
            end
            if (said >= pat_count || pat_gap == 0)
                break;
            if ((now - phase_t) < pat_gap)
                return;
            phase_t = phase_t + pat_gap;
            in_tone = 1'b1;
            said    = said + 8'd1;
        end
        if (pat_again == 0)
            return;
        if ((now - announce_t) >= pat_again)
            begin_voice(voice, v_level, now);
    endfunction

    // Expected tone item for one accepted update.
    function automatic tone_t tone_for_update(upd_row_t u);
        tone_t t;
        if (!u.running || !u.enabled)
            silence();
        else
        begin
            if (u.level != LVL_NONE)
            begin
                if (voice != VOICE_TRAFFIC || v_level != u.level || u.escalated)
                    begin_voice(VOICE_TRAFFIC, u.level, u.now_ms);
            end
            else if (voice == VOICE_TRAFFIC)
                silence();
            if (u.fix_req && voice != VOICE_TRAFFIC)
                begin_voice(VOICE_JINGLE, LVL_NONE, u.now_ms);
            voice_catch_up(u.now_ms);
        end
        t.tone_on      = (voice != VOICE_NONE) && in_tone;
        t.tone_lvl     = t.tone_on ? v_level : LVL_NONE;
        t.tone_freq_hz = t.tone_on ? freq : 16'd0;
        t.changed      = (t.tone_on != prev_on) || (t.tone_lvl != prev_level)
                         || (t.tone_freq_hz != prev_hz);
        prev_on    = t.tone_on;
        prev_level = t.tone_lvl;
        prev_hz    = t.tone_freq_hz;
        return t;
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off on request.
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_res)
            begin
                res_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_res = 1'b0;
            end
            res_ch.ready <= no_idle || ($urandom_range(0, 99) >= 34);
        end
    end

    // Compare each result item with the oldest expectation.
    always @(posedge clk)
    begin
        tone_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (tones_due.size() == 0)
            begin
                $error("result item with no expectation waiting");
                errors++;
            end
            else
            begin
                e = tones_due.pop_front();
                if (res_ch.tone_on !== e.tone_on)
                begin
                    $error("tone_on expected %0d actual %0d", e.tone_on, res_ch.tone_on);
                    errors++;
                end
                if (res_ch.tone_lvl !== e.tone_lvl)
                begin
                    $error("tone_lvl expected %0d actual %0d", e.tone_lvl,
                           res_ch.tone_lvl);
                    errors++;
                end
                if (res_ch.tone_freq_hz !== e.tone_freq_hz)
                begin
                    $error("tone_freq_hz expected %0d actual %0d", e.tone_freq_hz,
                           res_ch.tone_freq_hz);
                    errors++;
                end
                if (res_ch.changed !== e.changed)
                begin
                    $error("changed expected %0d actual %0d", e.changed, res_ch.changed);
                    errors++;
                end
            end
        end
    end

    // Offer one update, with random idle cycles in front of it.
    task automatic send_update(upd_row_t u);
        tone_t t;
        while (!no_idle && $urandom_range(0, 99) < 34)
        begin
            upd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        upd_ch.valid       <= 1'b1;
        upd_ch.running     <= u.running;
        upd_ch.enabled     <= u.enabled;
        upd_ch.alert_level <= u.level;
        upd_ch.escalated   <= u.escalated;
        upd_ch.fix_req     <= u.fix_req;
        upd_ch.now_ms      <= u.now_ms;
        do
            @(posedge clk);
        while (!upd_ch.ready);
        t = tone_for_update(u);
        if (u.typed)
            t = '{u.exp_on, u.exp_level, u.exp_hz, u.exp_changed};
        tones_due.push_back(t);
        sent++;
    endtask

    // Stop offering and wait until every expected item has arrived.
    task automatic drain();
        upd_ch.valid <= 1'b0;
        @(posedge clk);
        while (tones_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        regs_write(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic upd_row_t row(logic r, logic en, logic [1:0] lvl, logic esc,
                                     logic ff, logic [31:0] now);
        upd_row_t u;
        u = '{r, en, lvl, esc, ff, now, 1'b0, 1'b0, 2'd0, 16'd0, 1'b0};
        return u;
    endfunction

    function automatic upd_row_t typed_row(upd_row_t u, logic on, logic [1:0] lvl,
                                           logic [15:0] hz, logic ch);
        u.typed       = 1'b1;
        u.exp_on      = on;
        u.exp_level   = lvl;
        u.exp_hz      = hz;
        u.exp_changed = ch;
        return u;
    endfunction

    upd_row_t directed[$];

    initial
    begin
        upd_row_t u;
        logic [31:0] now;
        logic [1:0]  lvl;
        int pick;

        errors   = 0;
        sent     = 0;
        cycles   = 0;
        no_idle  = 1'b0;
        hold_res = 1'b0;
        rst_n    = 1'b0;
        upd_ch.valid       <= 1'b0;
        upd_ch.running     <= 1'b0;
        upd_ch.enabled     <= 1'b0;
        upd_ch.alert_level <= LVL_NONE;
        upd_ch.escalated   <= 1'b0;
        upd_ch.fix_req     <= 1'b0;
        upd_ch.now_ms      <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        regs_reset();
        silence();
        announce_t = '0; phase_t = '0; note_no = '0;
        prev_on = 1'b0; prev_level = '0; prev_hz = '0;
        pat_tone = '0; pat_gap = '0; pat_count = '0; pat_again = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with register defaults.
        directed.push_back(typed_row(row(NO, YES, LVL_URGENT, NO, NO, 32'd100),
                                     NO, LVL_NONE, 16'd0, NO));
        directed.push_back(typed_row(row(YES, NO, LVL_URGENT, NO, YES, 32'd100),
                                     NO, LVL_NONE, 16'd0, NO));
        directed.push_back(typed_row(row(YES, YES, LVL_NONE, NO, NO, 32'd100),
                                     NO, LVL_NONE, 16'd0, NO));
        directed.push_back(typed_row(row(YES, YES, LVL_INFO, NO, NO, 32'd200),
                                     YES, LVL_INFO, 16'd0, YES));
        directed.push_back(row(YES, YES, LVL_INFO, NO, NO, 32'd259));
        directed.push_back(row(YES, YES, LVL_INFO, NO, NO, 32'd260));
        directed.push_back(typed_row(row(YES, YES, LVL_IMPORTANT, NO, NO, 32'd300),
                                     YES, LVL_IMPORTANT, 16'd0, YES));
        directed.push_back(row(YES, YES, LVL_IMPORTANT, NO, NO, 32'd900));
        directed.push_back(row(YES, YES, LVL_URGENT, NO, NO, 32'd1000));
        directed.push_back(row(YES, YES, LVL_URGENT, YES, NO, 32'd1050));
        directed.push_back(row(YES, YES, LVL_URGENT, NO, YES, 32'd1400));
        directed.push_back(row(YES, YES, LVL_URGENT, NO, NO, 32'd20000));
        directed.push_back(typed_row(row(YES, YES, LVL_NONE, NO, YES, 32'd20010),
                                     YES, LVL_NONE, 16'd523, YES));
        directed.push_back(row(YES, YES, LVL_NONE, NO, YES, 32'd20050));
        directed.push_back(row(YES, YES, LVL_NONE, NO, NO, 32'd20200));
        directed.push_back(row(YES, YES, LVL_NONE, NO, NO, 32'd20500));
        directed.push_back(row(YES, YES, LVL_NONE, NO, NO, 32'd21500));
        directed.push_back(row(YES, YES, LVL_INFO, NO, YES, 32'd21600));
        directed.push_back(row(YES, YES, LVL_URGENT, NO, NO, 32'hFFFF_FFF0));
        directed.push_back(row(YES, YES, LVL_URGENT, NO, NO, 32'h0000_00A0));
        directed.push_back(row(YES, YES, LVL_URGENT, YES, YES, 32'hFFFF_FFFF));
        directed.push_back(typed_row(row(NO, NO, LVL_URGENT, YES, YES, 32'hFFFF_FFFF),
                                     NO, LVL_NONE, 16'd0, YES));
        foreach (directed[i])
            send_update(directed[i]);
        drain();

        // Random part, one register setting per phase.
        now = $urandom;
        lvl = LVL_NONE;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_INFO_TONE, 32'hFFFF);
                    write_reg(REG_INFO_COUNT, 32'hFF);
                    write_reg(REG_PAIR_TONE, 32'hFFFF);
                    write_reg(REG_PAIR_COUNT, 32'hFF);
                    write_reg(REG_TRAIN_TONE, 32'hFFFF);
                    write_reg(REG_TRAIN_CNT, 32'hFF);
                    write_reg(REG_REANNOUNCE, 32'hFFFF_FFFF);
                end
                1:
                begin
                    write_reg(REG_INFO_TONE, 32'd0);
                    write_reg(REG_INFO_COUNT, 32'd0);
                    write_reg(REG_PAIR_TONE, 32'd0);
                    write_reg(REG_PAIR_COUNT, 32'd3);
                    write_reg(REG_TRAIN_TONE, 32'd40);
                    write_reg(REG_TRAIN_CNT, 32'd0);
                    write_reg(REG_REANNOUNCE, 32'd0);
                end
                2:
                begin
                    // Tight patterns so that late updates cross many phases.
                    write_reg(REG_INFO_TONE, 32'd1);
                    write_reg(REG_INFO_COUNT, 32'd255);
                    write_reg(REG_PAIR_TONE, 32'd1);
                    write_reg(REG_PAIR_COUNT, 32'd255);
                    write_reg(REG_TRAIN_TONE, 32'd2);
                    write_reg(REG_TRAIN_CNT, 32'd200);
                    write_reg(REG_REANNOUNCE, 32'd700);
                    write_reg(REG_SPARE_LO, $urandom);
                    write_reg(REG_SPARE_HI, $urandom);
                end
                default:
                begin
                    write_reg(REG_INFO_TONE, $urandom_range(0, 80));
                    write_reg(REG_INFO_COUNT, $urandom_range(0, 3));
                    write_reg(REG_PAIR_TONE, $urandom_range(0, 60));
                    write_reg(REG_PAIR_COUNT, $urandom_range(0, 6));
                    write_reg(REG_TRAIN_TONE, $urandom_range(1, 50));
                    write_reg(REG_TRAIN_CNT, $urandom_range(0, 8));
                    write_reg(REG_REANNOUNCE, $urandom_range(0, 1500));
                end
            endcase

            for (int i = 0; i < RAND_ITEMS / PHASES; i++)
            begin
                no_idle = (ph == 3) && (i < 120);
                if (ph == 4 && i == 50)
                    hold_res = 1'b1;
                if (ph == 4 && i == 150)
                    drain();
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    now = now + $urandom_range(0, 60);
                else if (pick < 96)
                    now = now + $urandom_range(0, 3000);
                else
                    now = $urandom;
                if ($urandom_range(0, 99) < 12)
                    lvl = 2'($urandom_range(0, 3));
                u = row($urandom_range(0, 99) < 95, $urandom_range(0, 99) < 95, lvl,
                        $urandom_range(0, 99) < 5, $urandom_range(0, 99) < 10, now);
                send_update(u);
            end
            no_idle = 1'b0;
            drain();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/atps_pkg.sv
hw/rtl/atps_upd_if.sv
hw/rtl/atps_res_if.sv
hw/rtl/atps_cfg_if.sv
hw/rtl/atps_ctrl.sv
hw/rtl/atps_datapath.sv
hw/rtl/alert_tone_pattern_sequencer.sv
hw/rtl/atps_checker.sv
sim/tb.sv
